// ----- hdl/bvt_pkg.sv -----
`default_nettype none

package bvt_pkg;

  // fixed field widths
  localparam int DataW = 32;
  localparam int PosW  = 9;
  localparam int CmdW  = 3;
  localparam int StatW = 2;

  // default number of entries
  localparam int DefaultCapacity = 256;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_READ   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_RESIZE = 3'd4,
    CMD_FILL   = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_CAPACITY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_FIND,
    S_SWEEP,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/bvt_ram.sv -----
`default_nettype none

module bvt_ram import bvt_pkg::*; #(
  parameter int Depth = DefaultCapacity,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bounded_vector_table_core.sv -----
// write, rejected and unused commands go straight to the response state; read passes through
// the read state first; insert shifts the entries from the position up one place, then writes;
// find reads ahead and compares entry by entry; resize and fill sweep up to the new length
// one item at a time; the single-port-write entry memory bounds the shift, search and sweep
// walks to one entry per cycle, so an item holds the input until its result is loaded out
// reset clears the length, the sequencer and the output valid; entry memory is not cleared
`default_nettype none

module bounded_vector_table_core import bvt_pkg::*; #(
  parameter int CAPACITY = DefaultCapacity
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [CmdW-1:0]         cmd_i,
  input  wire logic [PosW-1:0]         position_i,
  input  wire logic signed [DataW-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [StatW-1:0]             status_o,
  output logic signed [DataW-1:0]      read_value_o,
  output logic                         found_o,
  output logic signed [PosW-1:0]       found_index_o,
  output logic [PosW-1:0]              length_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > PosW) ? LW : PosW;

  // control registers
  state_e         state_q, state_d;
  logic [LW-1:0]  len_q, len_d;
  logic           out_valid_q, out_valid_d;

  // payload registers
  logic [LW-1:0]    ptr_q, ptr_d;
  logic [LW-1:0]    rem_q, rem_d;
  logic [LW-1:0]    end_q, end_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;
  status_e          res_status_q, res_status_d;
  logic [DataW-1:0] res_rd_q, res_rd_d;
  logic             res_found_q, res_found_d;
  logic [PosW-1:0]  res_fidx_q, res_fidx_d;
  logic [StatW-1:0] out_status_q;
  logic [DataW-1:0] out_rd_q;
  logic             out_found_q;
  logic [PosW-1:0]  out_fidx_q;
  logic [PosW-1:0]  out_len_q;

  // memory port
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  logic             in_xfer;
  logic [CW-1:0]    pos_w, len_w, cap_w;
  logic [LW-1:0]    ptr_dec, ptr_inc;
  logic [AW-1:0]    pend_inc;

  bvt_ram #(
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign pos_w      = CW'(position_i);
  assign len_w      = CW'(len_q);
  assign cap_w      = CW'(CAPACITY);
  assign ptr_dec    = ptr_q - LW'(1);
  assign ptr_inc    = ptr_q + LW'(1);
  assign pend_inc   = pend_idx_q + AW'(1);

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ptr_d        = ptr_q;
    rem_d        = rem_q;
    end_d        = end_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    pos_d        = pos_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    res_found_d  = res_found_q;
    res_fidx_d   = res_fidx_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q[AW-1:0];
    mem_wdata    = val_q;
    mem_re       = 1'b0;
    mem_raddr    = pos_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pos_d        = pos_w;
          val_d        = value_i;
          res_status_d = ST_OK;
          res_rd_d     = '0;
          res_found_d  = 1'b0;
          res_fidx_d   = '0;
          pend_d       = 1'b0;
          state_d      = S_RESP;
          case (cmd_e'(cmd_i))
            CMD_INSERT: begin
              if (pos_w > len_w) begin
                res_status_d = ST_RANGE;
              end else if (len_w >= cap_w) begin
                res_status_d = ST_CAPACITY;
              end else begin
                ptr_d   = len_q;
                rem_d   = LW'(len_w - pos_w);
                state_d = S_SHIFT;
              end
            end
            CMD_READ: begin
              if (pos_w >= len_w) begin
                res_status_d = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = position_i[AW-1:0];
                state_d   = S_READ;
              end
            end
            CMD_WRITE: begin
              if (pos_w >= len_w) begin
                res_status_d = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = position_i[AW-1:0];
                mem_wdata = value_i;
              end
            end
            CMD_FIND: begin
              res_fidx_d = '1;
              ptr_d      = '0;
              state_d    = S_FIND;
            end
            CMD_RESIZE: begin
              if (pos_w > cap_w) begin
                res_status_d = ST_CAPACITY;
              end else begin
                ptr_d   = len_q;
                end_d   = LW'(pos_w);
                val_d   = '0;
                state_d = S_SWEEP;
              end
            end
            CMD_FILL: begin
              if (pos_w > cap_w) begin
                res_status_d = ST_CAPACITY;
              end else begin
                ptr_d   = '0;
                end_d   = LW'(pos_w);
                state_d = S_SWEEP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_READ: begin
        res_rd_d = mem_rdata;
        state_d  = S_RESP;
      end

      // walk down from the top, writing each entry one place higher
      S_SHIFT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_inc;
          mem_wdata = mem_rdata;
        end
        if (rem_q != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_dec[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = ptr_dec[AW-1:0];
          ptr_d      = ptr_dec;
          rem_d      = rem_q - LW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q[AW-1:0];
            mem_wdata = val_q;
            len_d     = len_q + LW'(1);
            state_d   = S_RESP;
          end
        end
      end

      // read ahead one entry, compare the one that came back
      S_FIND: begin
        if (pend_q && (mem_rdata == val_q)) begin
          res_found_d = 1'b1;
          res_fidx_d  = PosW'(pend_idx_q);
          pend_d      = 1'b0;
          state_d     = S_RESP;
        end else if (ptr_q < len_q) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_q[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[AW-1:0];
          ptr_d      = ptr_inc;
        end else begin
          pend_d  = 1'b0;
          state_d = S_RESP;
        end
      end

      // zero or value fill up to the new length
      S_SWEEP: begin
        if (ptr_q < end_q) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q[AW-1:0];
          mem_wdata = val_q;
          ptr_d     = ptr_inc;
        end else begin
          len_d   = end_q;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    rem_q        <= rem_d;
    end_q        <= end_d;
    pend_q       <= pend_d;
    pend_idx_q   <= pend_idx_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    res_found_q  <= res_found_d;
    res_fidx_q   <= res_fidx_d;
  end

  // output register, loaded on leaving the response state
  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_rd_q     <= res_rd_q;
      out_found_q  <= res_found_q;
      out_fidx_q   <= res_fidx_q;
      out_len_q    <= PosW'(len_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_rd_q;
  assign found_o       = out_found_q;
  assign found_index_o = out_fidx_q;
  assign length_o      = out_len_q;

  // length never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("length beyond capacity");

  // a pending find compare always refers to a live entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && pend_q) |-> (LW'(pend_idx_q) < len_q))
    else $error("find compare outside live entries");

  // finishing an insert grows the length by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d == S_RESP) |=> (len_q == $past(len_q) + LW'(1)))
    else $error("insert did not grow length");

  // a match is only ever reported with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> (out_status_q == ST_OK))
    else $error("match reported with error status");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
  import bvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity    = DefaultCapacity;
  localparam int RandomItems = 1525;
  localparam int DrainCycles = 300;
  localparam int CycleLimit  = 3000000;
  localparam int PrintLimit  = 40;
  localparam int MaxPosition = (1 << PosW) - 1;

  // command codes the block leaves unused
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  // found index when the value is absent
  localparam logic [PosW-1:0] NotFound = '1;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [PosW-1:0]  position;
    logic [DataW-1:0] value;
    int               phase;
  } table_cmd_t;

  typedef struct {
    logic [StatW-1:0] status;
    logic [DataW-1:0] read_value;
    logic             found;
    logic [PosW-1:0]  found_index;
    logic [PosW-1:0]  length;
  } table_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid    = 1'b0;
  logic [CmdW-1:0]         in_cmd      = '0;
  logic [PosW-1:0]         in_position = '0;
  logic signed [DataW-1:0] in_value    = '0;
  logic                    out_ready   = 1'b0;

  logic                    in_ready;
  logic                    out_valid;
  logic [StatW-1:0]        out_status;
  logic signed [DataW-1:0] out_read_value;
  logic                    out_found;
  logic signed [PosW-1:0]  out_found_index;
  logic [PosW-1:0]         out_length;

  // shadow copy of the array
  logic [DataW-1:0] table_words [Capacity];
  int               table_length = 0;

  table_cmd_t   cmds_pending [$];
  table_reply_t replies_due  [$];

  int mismatch_count = 0;
  int cur_phase      = 0;
  int cycle_count    = 0;

  // stimulus-side length tracking and a value pool so finds hit
  int               gen_length = 0;
  int               gen_phase  = 0;
  logic [DataW-1:0] value_pool [8];

  bounded_vector_table_core #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (in_cmd),
    .position_i    (in_position),
    .value_i       (in_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (out_status),
    .read_value_o  (out_read_value),
    .found_o       (out_found),
    .found_index_o (out_found_index),
    .length_o      (out_length)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // apply one command to the shadow array and return its reply
  function automatic table_reply_t run_table_cmd(input table_cmd_t c);
    table_reply_t r;
    int           pos;
    r.status      = ST_OK;
    r.read_value  = '0;
    r.found       = 1'b0;
    r.found_index = '0;
    pos           = int'(c.position);
    case (c.cmd)
      CMD_INSERT: begin
        if (pos > table_length) begin
          r.status = ST_RANGE;
        end else if (table_length >= Capacity) begin
          r.status = ST_CAPACITY;
        end else begin
          for (int i = table_length; i > pos; i--) table_words[i] = table_words[i-1];
          table_words[pos] = c.value;
          table_length++;
        end
      end
      CMD_READ: begin
        if (pos >= table_length) r.status = ST_RANGE;
        else r.read_value = table_words[pos];
      end
      CMD_WRITE: begin
        if (pos >= table_length) r.status = ST_RANGE;
        else table_words[pos] = c.value;
      end
      CMD_FIND: begin
        r.found_index = NotFound;
        for (int i = 0; i < table_length; i++) begin
          if (table_words[i] == c.value) begin
            r.found       = 1'b1;
            r.found_index = i[PosW-1:0];
            break;
          end
        end
      end
      CMD_RESIZE: begin
        if (pos > Capacity) begin
          r.status = ST_CAPACITY;
        end else begin
          for (int i = table_length; i < pos; i++) table_words[i] = '0;
          table_length = pos;
        end
      end
      CMD_FILL: begin
        if (pos > Capacity) begin
          r.status = ST_CAPACITY;
        end else begin
          for (int i = 0; i < pos; i++) table_words[i] = c.value;
          table_length = pos;
        end
      end
      default: begin
      end
    endcase
    r.length = table_length[PosW-1:0];
    return r;
  endfunction

  // idle percentage per phase for each side
  function automatic int idle_pct(input int phase, input logic receiver);
    case (phase)
      0:       return receiver ? 53 : 9;
      1:       return receiver ? 9 : 53;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) begin
      $display("mismatch on %s: got %0h, want %0h", field, got, want);
    end
  endtask

  // queue one command and track the length it leaves behind
  task automatic queue_cmd(input logic [CmdW-1:0] cmd, input int pos,
                           input logic [DataW-1:0] val);
    table_cmd_t c;
    c.cmd      = cmd;
    c.position = pos[PosW-1:0];
    c.value    = val;
    c.phase    = gen_phase;
    cmds_pending.insert(cmds_pending.size(), c);
    case (cmd)
      CMD_INSERT: if (pos <= gen_length && gen_length < Capacity) gen_length++;
      CMD_RESIZE, CMD_FILL: if (pos <= Capacity) gen_length = pos;
      default: begin
      end
    endcase
  endtask

  // mostly values already in use, sometimes fresh ones
  function automatic logic [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) value_pool[$urandom_range(0, 7)] = $urandom;
    if (r < 60) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // new length for resize and fill: mostly short, a few longer up to full, a few too long
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(0, 24);
    if (r < 96) return $urandom_range(25, Capacity);
    return $urandom_range(Capacity + 1, MaxPosition);
  endfunction

  // index for read and write: mostly live, sometimes out of range
  function automatic int pick_index();
    if (gen_length > 0 && $urandom_range(0, 99) < 80) return $urandom_range(0, gen_length - 1);
    return $urandom_range(gen_length, MaxPosition);
  endfunction

  task automatic queue_random_cmd();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 30) begin
      if (s < 80) queue_cmd(CMD_INSERT, $urandom_range(0, gen_length), pick_value());
      else if (s < 90) queue_cmd(CMD_INSERT, gen_length, pick_value());
      else queue_cmd(CMD_INSERT, $urandom_range(gen_length + 1, MaxPosition), pick_value());
    end else if (r < 50) begin
      queue_cmd(CMD_READ, pick_index(), $urandom);
    end else if (r < 65) begin
      queue_cmd(CMD_WRITE, pick_index(), pick_value());
    end else if (r < 80) begin
      queue_cmd(CMD_FIND, $urandom_range(0, MaxPosition), pick_value());
    end else if (r < 88) begin
      queue_cmd(CMD_RESIZE, pick_length(), $urandom);
    end else if (r < 95) begin
      queue_cmd(CMD_FILL, pick_length(), pick_value());
    end else if (r < 98) begin
      queue_cmd((s < 50) ? CmdSpareLo : CmdSpareHi, $urandom_range(0, MaxPosition), $urandom);
    end else begin
      queue_cmd($urandom_range(0, 7), $urandom_range(0, MaxPosition), $urandom);
    end
  endtask

  // driver: launch the next queued command when the slot is free
  always @(posedge clk_i) begin : cmd_driver
    table_cmd_t c;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        c.cmd      = in_cmd;
        c.position = in_position;
        c.value    = in_value;
        c.phase    = cur_phase;
        replies_due.insert(replies_due.size(), run_table_cmd(c));
      end
      if (!in_valid || in_ready) begin
        if (cmds_pending.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(cmds_pending[0].phase, 1'b0)) begin
          c            = cmds_pending.pop_front();
          in_valid    <= 1'b1;
          in_cmd      <= c.cmd;
          in_position <= c.position;
          in_value    <= c.value;
          cur_phase   <= c.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each reply transfer with the oldest one due
  always @(posedge clk_i) begin : reply_monitor
    table_reply_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with nothing due", '0, '0);
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_read_value !== want.read_value) begin
            report_mismatch("read_value", out_read_value, want.read_value);
          end
          if (out_found !== want.found) report_mismatch("found", out_found, want.found);
          if (out_found_index !== want.found_index) begin
            report_mismatch("found_index", out_found_index, want.found_index);
          end
          if (out_length !== want.length) report_mismatch("length", out_length, want.length);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(cur_phase, 1'b1));
    end
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    for (int i = 0; i < Capacity; i++) table_words[i] = '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // empty array: every access is out of range, find misses
    queue_cmd(CMD_READ, 0, 32'h0);
    queue_cmd(CMD_WRITE, 0, 32'h1234_5678);
    queue_cmd(CMD_FIND, 0, 32'h0);
    queue_cmd(CMD_INSERT, 1, 32'h1);
    // inserts at the front, at the end and in the middle
    queue_cmd(CMD_INSERT, 0, 32'h7fff_ffff);
    queue_cmd(CMD_INSERT, 0, 32'h8000_0000);
    queue_cmd(CMD_INSERT, 2, 32'hffff_ffff);
    queue_cmd(CMD_INSERT, 1, 32'h0);
    queue_cmd(CMD_READ, 3, 32'h0);
    queue_cmd(CMD_READ, 4, 32'h0);
    queue_cmd(CMD_WRITE, 1, 32'h5555_5555);
    queue_cmd(CMD_FIND, MaxPosition, 32'h7fff_ffff);
    queue_cmd(CMD_FIND, 0, 32'h1234_5678);
    // shrink then grow: new entries are zero, which the find then checks
    queue_cmd(CMD_RESIZE, 2, 32'h0);
    queue_cmd(CMD_RESIZE, 5, 32'hffff_ffff);
    queue_cmd(CMD_FIND, 0, 32'h0);
    // growth past capacity, then a full array
    queue_cmd(CMD_RESIZE, Capacity + 1, 32'h0);
    queue_cmd(CMD_FILL, MaxPosition, 32'h1);
    queue_cmd(CMD_FILL, Capacity, 32'haaaa_aaaa);
    queue_cmd(CMD_INSERT, Capacity, 32'h1);
    queue_cmd(CMD_INSERT, Capacity + 1, 32'h1);
    queue_cmd(CMD_READ, Capacity - 1, 32'h0);
    // unused codes, then back to empty
    queue_cmd(CmdSpareLo, MaxPosition, 32'hffff_ffff);
    queue_cmd(CmdSpareHi, 0, 32'h0);
    queue_cmd(CMD_FILL, 0, 32'h0);

    for (int i = 0; i < RandomItems; i++) begin
      gen_phase = (i * 3) / RandomItems;
      queue_random_cmd();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
